/* hw/rtl/fmod_pkg.sv */
// ---------------------------------------------------------------------------
// fmod_pkg
// Types and constants shared by the binary64 remainder unit.
// ---------------------------------------------------------------------------
package fmod_pkg;

    localparam logic [63:0] SIGN_BIT    = 64'h8000_0000_0000_0000;
    localparam logic [63:0] EXP_MASK    = 64'h7FF0_0000_0000_0000;
    localparam logic [63:0] FRAC_MASK   = 64'h000F_FFFF_FFFF_FFFF;
    localparam logic [63:0] QUIET_BIT   = 64'h0008_0000_0000_0000;
    localparam logic [63:0] DEFAULT_NAN = 64'h7FF8_0000_0000_0000;

    typedef struct packed {
        logic [63:0] dividend;
        logic [63:0] divisor;
    } t_in;

    typedef struct packed {
        logic [63:0] remainder;
        logic        invalid;
    } t_out;

    // Commands from controller to datapath.
    typedef struct packed {
        logic load;      // capture operands and classify
        logic norm_x;    // normalise dividend significand one bit
        logic norm_y;    // normalise divisor significand one bit
        logic step;      // one shift-and-subtract step
        logic last;      // final subtract
        logic norm_r;    // renormalise result one bit
        logic denorm;    // shift result right one bit towards subnormal
        logic finish;    // pack result
    } t_cmd;

    // Status from datapath to controller.
    typedef struct packed {
        logic special;   // result already settled at load
        logic x_norm;    // dividend significand has hidden bit
        logic y_norm;    // divisor significand has hidden bit
        logic ex_gt_ey;  // more steps to go
        logic zero;      // remainder became zero
        logic r_norm;    // result significand has hidden bit
        logic e_pos;     // result exponent above zero
        logic r_gone;    // result shifted entirely out
    } t_sts;

endpackage

/* hw/rtl/fmod_datapath.sv */
// ---------------------------------------------------------------------------
// fmod_datapath
// Operand registers, significand subtractor and exponent counters.
// ---------------------------------------------------------------------------
module fmod_datapath import fmod_pkg::*; (
    input  logic        i_clk,
    input  t_in         i_in,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    output t_out        o_res
);

    logic [63:0] r_res, n_res;
    logic        r_inv, n_inv;
    logic        r_special, n_special;
    logic        r_zero, n_zero;
    logic        r_sign, n_sign;
    // The partial remainder is below twice the divisor, so it needs one bit more.
    logic [53:0] r_mx, n_mx;
    logic [52:0] r_my, n_my;
    logic signed [12:0] r_ex, n_ex;
    logic signed [12:0] r_ey, n_ey;
    logic [54:0] diff;
    logic        ge;

    logic [62:0] ax, ay;
    logic        x_nan, y_nan, x_inf, y_inf, x_zero, y_zero;

    assign ax     = i_in.dividend[62:0];
    assign ay     = i_in.divisor[62:0];
    assign x_nan  = (ax[62:52] == 11'h7FF) && (ax[51:0] != '0);
    assign y_nan  = (ay[62:52] == 11'h7FF) && (ay[51:0] != '0);
    assign x_inf  = ax == EXP_MASK[62:0];
    assign y_inf  = ay == EXP_MASK[62:0];
    assign x_zero = ax == '0;
    assign y_zero = ay == '0;

    assign diff = {1'b0, r_mx} - {2'b00, r_my};
    assign ge   = !diff[54];

    always_comb begin
        n_res = r_res; n_inv = r_inv; n_special = r_special; n_zero = r_zero;
        n_sign = r_sign; n_mx = r_mx; n_my = r_my; n_ex = r_ex; n_ey = r_ey;
        if (i_cmd.load) begin
            n_inv     = 1'b0;
            n_zero    = 1'b0;
            n_special = 1'b1;
            n_sign    = i_in.dividend[63];
            n_mx      = {1'b0, (ax[62:52] != '0), ax[51:0]};
            n_my      = {(ay[62:52] != '0), ay[51:0]};
            n_ex      = (ax[62:52] == '0) ? 13'sd1 : $signed({2'b00, ax[62:52]});
            n_ey      = (ay[62:52] == '0) ? 13'sd1 : $signed({2'b00, ay[62:52]});
            if (x_nan) begin
                n_res = i_in.dividend | QUIET_BIT;
            end else if (y_nan) begin
                n_res = i_in.divisor | QUIET_BIT;
            end else if (x_inf || y_zero) begin
                n_res = DEFAULT_NAN;
                n_inv = 1'b1;
            end else if (y_inf || x_zero || ax < ay) begin
                n_res = i_in.dividend;
            end else if (ax == ay) begin
                n_res = {i_in.dividend[63], 63'd0};
            end else begin
                n_special = 1'b0;
            end
        end
        if (i_cmd.norm_x) begin
            n_mx = {r_mx[52:0], 1'b0};
            n_ex = r_ex - 13'sd1;
        end
        if (i_cmd.norm_y) begin
            n_my = {r_my[51:0], 1'b0};
            n_ey = r_ey - 13'sd1;
        end
        if (i_cmd.step || i_cmd.last) begin
            if (ge) begin
                n_mx = diff[53:0];
                if (diff[53:0] == '0) n_zero = 1'b1;
            end
            if (i_cmd.step) begin
                n_mx = ge ? {diff[52:0], 1'b0} : {r_mx[52:0], 1'b0};
                n_ex = r_ex - 13'sd1;
            end
        end
        if (i_cmd.norm_r) begin
            n_mx = {r_mx[52:0], 1'b0};
            n_ex = r_ex - 13'sd1;
        end
        if (i_cmd.denorm) begin
            n_mx = {1'b0, r_mx[53:1]};
            n_ex = r_ex + 13'sd1;
        end
        if (i_cmd.finish) begin
            if (r_zero) begin
                n_res = {r_sign, 63'd0};
            end else if (r_ex > 0) begin
                // A result shifted down into the subnormal range has lost its
                // hidden bit, and its stored exponent field is then zero.
                n_res = {r_sign, (r_mx[52] ? r_ex[10:0] : 11'd0), r_mx[51:0]};
            end else begin
                // Result was shifted entirely out before the exponent rose above zero: stored field is zero.
                n_res = {r_sign, 11'd0, r_mx[51:0]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res; r_inv <= n_inv; r_special <= n_special;
        r_zero <= n_zero; r_sign <= n_sign; r_mx <= n_mx; r_my <= n_my;
        r_ex <= n_ex; r_ey <= n_ey;
    end

    assign o_sts.special  = r_special;
    assign o_sts.x_norm   = r_mx[52];
    assign o_sts.y_norm   = r_my[52];
    assign o_sts.ex_gt_ey = r_ex > r_ey;
    assign o_sts.zero     = r_zero;
    assign o_sts.r_norm   = r_mx[52];
    assign o_sts.e_pos    = r_ex > 0;
    assign o_sts.r_gone   = r_mx == '0;
    assign o_res.remainder = r_res;
    assign o_res.invalid   = r_inv;

endmodule

/* hw/rtl/fmod_ctrl.sv */
// ---------------------------------------------------------------------------
// fmod_ctrl
// Sequencer for the remainder unit and the output beat register handshake.
// ---------------------------------------------------------------------------
module fmod_ctrl import fmod_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    output logic o_valid,
    input  logic i_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CLASS = 3'd1;
    localparam logic [2:0] S_NORM  = 3'd2;
    localparam logic [2:0] S_LOOP  = 3'd3;
    localparam logic [2:0] S_RNORM = 3'd4;
    localparam logic [2:0] S_DENRM = 3'd5;
    localparam logic [2:0] S_PACK  = 3'd6;
    localparam logic [2:0] S_OUT   = 3'd7;

    logic [2:0] r_state, n_state;

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CLASS;
                end
            end
            S_CLASS: n_state = i_sts.special ? S_OUT : S_NORM;
            S_NORM: begin
                if (!i_sts.x_norm) begin
                    o_cmd.norm_x = 1'b1;
                end
                if (!i_sts.y_norm) begin
                    o_cmd.norm_y = 1'b1;
                end
                if (i_sts.x_norm && i_sts.y_norm) n_state = S_LOOP;
            end
            S_LOOP: begin
                if (i_sts.zero) begin
                    n_state = S_PACK;
                end else if (i_sts.ex_gt_ey) begin
                    o_cmd.step = 1'b1;
                end else begin
                    o_cmd.last = 1'b1;
                    n_state    = S_RNORM;
                end
            end
            S_RNORM: begin
                if (i_sts.zero) begin
                    n_state = S_PACK;
                end else if (!i_sts.r_norm) begin
                    o_cmd.norm_r = 1'b1;
                end else begin
                    n_state = S_DENRM;
                end
            end
            S_DENRM: begin
                if (i_sts.e_pos || i_sts.zero) begin
                    n_state = S_PACK;
                end else if (i_sts.r_gone) begin
                    n_state = S_PACK;
                end else begin
                    o_cmd.denorm = 1'b1;
                end
            end
            S_PACK: begin
                o_cmd.finish = 1'b1;
                n_state      = S_OUT;
            end
            S_OUT: if (i_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid)) else $error("ready and valid together");
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> r_state == S_IDLE) else $error("load outside idle");
    a_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> r_state == S_CLASS) else $error("load not followed");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid) else $error("result dropped");

endmodule

/* hw/rtl/float64_remainder_fmod_unit.sv */
// ---------------------------------------------------------------------------
// float64_remainder_fmod_unit
// Binary64 fmod with the dividend's sign; one item at a time.
// ---------------------------------------------------------------------------
// Special items (NaN, infinity, zero or smaller dividend) skip the loop;
// others take one shift-and-subtract step per unit of exponent difference,
// plus one shift per bit of subnormal normalisation, renormalisation and
// denormalisation. Each loop step uses the single 55-bit subtractor. A new
// beat is taken only after the previous result beat has been delivered.
module float64_remainder_fmod_unit import fmod_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_out o_data
);

    t_cmd cmd;
    t_sts sts;

    fmod_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .o_valid, .i_ready,
        .i_sts(sts), .o_cmd(cmd)
    );

    fmod_datapath u_dp (
        .i_clk, .i_in(i_data), .i_cmd(cmd), .o_sts(sts), .o_res(o_data)
    );

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the binary64 fmod unit: an independent predictor
// computes each remainder, and a monitor compares every result beat in order.
// ---------------------------------------------------------------------------
module tb;
    import fmod_pkg::*;

    localparam int DOG_LIMIT = 40000;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_ready;
    t_in  i_data;
    logic o_valid;
    logic i_ready;
    t_out o_data;

    t_out expected_q[$];
    int   error_count;
    int   idle_cycles;
    int   burst_left;
    logic stall_mode;

    float64_remainder_fmod_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    function automatic logic is_nan64(logic [63:0] v);
        return (v & EXP_MASK) == EXP_MASK && (v & FRAC_MASK) != 0;
    endfunction

    // Splits a finite nonzero magnitude; subnormals are normalised here.
    function automatic void split_mag(input logic [63:0] mag, output int e,
                                      output logic [63:0] m);
        e = int'(mag[62:52]);
        m = mag & FRAC_MASK;
        if (e == 0) begin
            e = 1;
            while (m[52] == 1'b0) begin
                m = m << 1;
                e--;
            end
        end else begin
            m[52] = 1'b1;
        end
    endfunction

    function automatic logic [63:0] magnitude_remainder(logic [63:0] x, logic [63:0] y);
        logic [63:0] sgn;
        logic [63:0] ax;
        logic [63:0] ay;
        logic [63:0] mx;
        logic [63:0] my;
        int ex;
        int ey;
        sgn = x & SIGN_BIT;
        ax = x & ~SIGN_BIT;
        ay = y & ~SIGN_BIT;
        if (ax < ay) return x;
        if (ax == ay) return sgn;
        split_mag(ax, ex, mx);
        split_mag(ay, ey, my);
        while (ex > ey) begin
            if (mx >= my) begin
                mx = mx - my;
                if (mx == 0) return sgn;
            end
            mx = mx << 1;
            ex--;
        end
        if (mx >= my) begin
            mx = mx - my;
            if (mx == 0) return sgn;
        end
        while (mx[52] == 1'b0) begin
            mx = mx << 1;
            ex--;
        end
        if (ex > 0) return sgn | (64'(ex) << 52) | (mx & FRAC_MASK);
        if (1 - ex > 63) return sgn;
        return sgn | (mx >> (1 - ex));
    endfunction

    function automatic t_out predict_fmod(t_in b);
        t_out r;
        r.invalid = 1'b0;
        if (is_nan64(b.dividend)) begin
            r.remainder = b.dividend | QUIET_BIT;
        end else if (is_nan64(b.divisor)) begin
            r.remainder = b.divisor | QUIET_BIT;
        end else if ((b.dividend & ~SIGN_BIT) == EXP_MASK || (b.divisor & ~SIGN_BIT) == 0) begin
            r.remainder = DEFAULT_NAN;
            r.invalid = 1'b1;
        end else if ((b.divisor & ~SIGN_BIT) == EXP_MASK || (b.dividend & ~SIGN_BIT) == 0) begin
            r.remainder = b.dividend;
        end else begin
            r.remainder = magnitude_remainder(b.dividend, b.divisor);
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH %s: got %h expected %h", what, got, want);
        error_count++;
    endtask

    // Sends one beat, honouring the burst and gap pattern of the sender.
    task automatic send_operands(input logic [63:0] x, input logic [63:0] y);
        t_in b;
        if (burst_left == 0) begin
            repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12)) @(posedge i_clk);
            burst_left = $urandom_range(1, 8);
        end
        burst_left--;
        b.dividend = x;
        b.divisor = y;
        i_valid <= 1'b1;
        i_data <= b;
        expected_q.push_back(predict_fmod(b));
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        i_valid <= 1'b0;
        // The unit is busy after it takes a beat, so nothing is lost here.
        @(posedge i_clk);
    endtask

    // Random double, biased towards nearby exponents so the loop stays short.
    function automatic logic [63:0] rand_double(int base_exp, int spread);
        logic [63:0] v;
        int e;
        v = {$urandom, $urandom};
        e = base_exp + $urandom_range(0, 2 * spread) - spread;
        if (e < 0) e = 0;
        if (e > 2046) e = 2046;
        v[62:52] = 11'(e);
        return v;
    endfunction

    task automatic wait_drained();
        while (expected_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_special_cases();
        send_operands(64'h7FF0_0000_0000_0001, 64'h3FF0_0000_0000_0000);
        send_operands(64'h3FF0_0000_0000_0000, 64'hFFF4_0000_0000_0000);
        send_operands(64'h7FF8_0000_0000_0000, 64'h7FF0_0000_0000_0002);
        send_operands(64'h7FF0_0000_0000_0000, 64'h4000_0000_0000_0000);
        send_operands(64'hFFF0_0000_0000_0000, 64'h0000_0000_0000_0000);
        send_operands(64'h4014_0000_0000_0000, 64'h8000_0000_0000_0000);
        send_operands(64'hC014_0000_0000_0000, 64'h7FF0_0000_0000_0000);
        send_operands(64'h8000_0000_0000_0000, 64'h3FF0_0000_0000_0000);
        send_operands(64'h0000_0000_0000_0000, 64'h0000_0000_0000_0001);
    endtask

    task automatic test_directed_values();
        send_operands(64'h3FF0_0000_0000_0000, 64'h4000_0000_0000_0000);
        send_operands(64'hC008_0000_0000_0000, 64'h3FF0_0000_0000_0000);
        send_operands(64'h4014_0000_0000_0000, 64'hC014_0000_0000_0000);
        send_operands(64'h401C_0000_0000_0000, 64'h4000_0000_0000_0000);
        send_operands(64'h000F_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0003);
        send_operands(64'h0010_0000_0000_0001, 64'h000F_FFFF_FFFF_FFFF);
        send_operands(64'h4024_CCCC_CCCC_CCCD, 64'h3FB9_9999_9999_999A);
        // Widest exponent gap: huge dividend over the smallest subnormal.
        send_operands(64'h7FEF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0001);
        send_operands(64'hFFEF_FFFF_FFFF_FFFF, 64'h0010_0000_0000_0000);
        send_operands(64'h7FEF_FFFF_FFFF_FFFF, 64'h7FEF_FFFF_FFFF_FFFE);
        send_operands(64'h3FF0_0000_0000_0001, 64'h0000_0000_0000_0007);
    endtask

    task automatic test_random_operands();
        int base_exp;
        int sel;
        logic [63:0] x;
        logic [63:0] y;
        for (int n = 0; n < 280; n++) begin
            base_exp = $urandom_range(0, 2046);
            x = rand_double(base_exp, 30);
            y = rand_double(base_exp, 30);
            sel = $urandom_range(0, 19);
            case (sel)
                0: x = {$urandom, $urandom};
                1: y = {$urandom, $urandom};
                2: x[62:52] = 11'h7FF;
                3: y[62:52] = 11'h7FF;
                4: y[62:0] = 63'(0);
                5: x[62:52] = 11'h000;
                6: y[62:52] = 11'h000;
                7: y = {x[63:52] + 12'($urandom_range(0, 1) ? 0 : 1), 52'($urandom_range(0, 15))};
                default: ;
            endcase
            if (n == 140) wait_drained();
            send_operands(x, y);
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data = '0;
        error_count = 0;
        burst_left = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_special_cases();
        test_directed_values();
        test_random_operands();
        wait_drained();
        repeat (50) @(posedge i_clk);
        if (error_count == 0) begin
            $display("float64_remainder_fmod_unit verification clean");
        end else begin
            $display("float64_remainder_fmod_unit verification failed");
        end
        $finish;
    end

    // Receiver stall pattern: alternates long open stretches with choppy ones.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            stall_mode <= 1'b0;
        end else begin
            if ($urandom_range(0, 63) == 0) stall_mode <= ~stall_mode;
            i_ready <= stall_mode ? ($urandom_range(0, 2) == 0) : 1'b1;
        end
    end

    // Compares each result beat with the oldest prediction.
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected beat", o_data.remainder, 64'h0);
            end else begin
                want = expected_q.pop_front();
                if (o_data.remainder !== want.remainder)
                    report_mismatch("remainder", o_data.remainder, want.remainder);
                if (o_data.invalid !== want.invalid)
                    report_mismatch("invalid", 64'(o_data.invalid), 64'(want.invalid));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= DOG_LIMIT) begin
                $display("float64_remainder_fmod_unit verification failed");
                $finish;
            end
        end
    end

endmodule
